>>> rtl/hashed_counter_random_range_top_defines.svh
// Assertion macros for the RTL of the hashed counter random range block.
// Needs nothing else; files that assert include it by name.
`ifndef HASHED_COUNTER_RANDOM_RANGE_TOP_DEFINES_SVH
`define HASHED_COUNTER_RANDOM_RANGE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HCRR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcrr assertion failed");

// Next-cycle implication, disabled during reset.
`define HCRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcrr assertion failed");

`endif

>>> rtl/hcrr_pkg.sv
// Package for the hashed counter random range block: widths, mixing constants,
// opcode and controller state types, and the controller-to-datapath command struct.
`default_nettype none

package hcrr_pkg;

    localparam int WORD_W   = 32;
    localparam int DIV_CNT_W = $clog2(WORD_W);

    localparam logic [WORD_W-1:0] STEP_ADD  = 32'he120fc15;
    localparam logic [WORD_W-1:0] MIX_MUL_A = 32'h4a39b70d;
    localparam logic [WORD_W-1:0] MIX_MUL_B = 32'h12fad5c9;
    localparam int                MIX_SHIFT = 16;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_DRAW = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MIX_B,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_seed;
        logic start_draw;
        logic mul_a;
        logic mul_b;
        logic fin_mix;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic span_zero;
    } status_t;

endpackage

`default_nettype wire

>>> rtl/hcrr_datapath.sv
// Datapath of the hashed counter random range block: counter, two multiply-xorshift
// rounds, a one-bit-per-cycle remainder unit and the result registers. Uses hcrr_pkg.
`default_nettype none

module hcrr_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire hcrr_pkg::cmd_t                cmd,
    output hcrr_pkg::status_t                  status,
    input  wire logic [hcrr_pkg::WORD_W-1:0]   seed_value,
    input  wire logic [hcrr_pkg::WORD_W-1:0]   min_value,
    input  wire logic [hcrr_pkg::WORD_W-1:0]   max_value,
    output logic      [hcrr_pkg::WORD_W-1:0]   raw_word,
    output logic      [hcrr_pkg::WORD_W-1:0]   ranged_value,
    output logic                               range_error
);
    import hcrr_pkg::*;

    logic [WORD_W-1:0] counter_reg;
    logic [WORD_W-1:0] counter_next;
    logic [WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] dvd_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] span_reg;
    logic [WORD_W-1:0] min_reg;
    logic [WORD_W-1:0] raw_out_reg;
    logic [WORD_W-1:0] ranged_out_reg;
    logic              err_out_reg;

    logic [WORD_W-1:0] prod_a;
    logic [WORD_W-1:0] mix_a;
    logic [WORD_W-1:0] prod_b;
    logic [WORD_W-1:0] mix_b;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   trial_diff;
    logic [WORD_W-1:0] rem_next;

    assign prod_a = counter_reg * MIX_MUL_A;
    assign mix_a  = prod_reg ^ (prod_reg >> MIX_SHIFT);
    assign prod_b = mix_a * MIX_MUL_B;
    assign mix_b  = prod_reg ^ (prod_reg >> MIX_SHIFT);

    assign trial      = {rem_reg, dvd_reg[WORD_W-1]};
    assign trial_diff = trial - {1'b0, span_reg};
    assign rem_next   = trial_diff[WORD_W] ? trial[WORD_W-1:0] : trial_diff[WORD_W-1:0];

    always_comb
    begin
        counter_next = counter_reg;
        if (cmd.load_seed)
        begin
            counter_next = seed_value;
        end
        else if (cmd.start_draw)
        begin
            counter_next = counter_reg + STEP_ADD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
        end
        else
        begin
            counter_reg <= counter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_draw)
        begin
            min_reg  <= min_value;
            span_reg <= max_value - min_value;
        end
        if (cmd.mul_a)
        begin
            prod_reg <= prod_a;
        end
        else if (cmd.mul_b)
        begin
            prod_reg <= prod_b;
        end
        if (cmd.fin_mix)
        begin
            word_reg <= mix_b;
            dvd_reg  <= mix_b;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_reg << 1;
        end
        if (cmd.load_out)
        begin
            raw_out_reg    <= word_reg;
            ranged_out_reg <= status.span_zero ? min_reg : rem_reg + min_reg;
            err_out_reg    <= status.span_zero;
        end
    end

    assign status.span_zero = (span_reg == '0);
    assign raw_word         = raw_out_reg;
    assign ranged_value     = ranged_out_reg;
    assign range_error      = err_out_reg;

endmodule

`default_nettype wire

>>> rtl/hcrr_ctrl.sv
// Controller of the hashed counter random range block: sequences the mixing rounds
// and the remainder steps and owns both handshakes. Uses hcrr_pkg.
`default_nettype none

module hcrr_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire hcrr_pkg::opcode_t  opcode,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output hcrr_pkg::cmd_t          cmd,
    input  wire hcrr_pkg::status_t  status
);
    import hcrr_pkg::*;

    localparam logic [DIV_CNT_W-1:0] DivLast = DIV_CNT_W'(WORD_W - 1);

    state_t               state_reg;
    state_t               state_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 accept;
    logic                 out_free;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && opcode == OP_DRAW)
                begin
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A: state_next = ST_MUL_B;
            ST_MUL_B: state_next = ST_MIX_B;
            ST_MIX_B: state_next = status.span_zero ? ST_DONE : ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == DivLast)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.load_seed  = accept && opcode == OP_LOAD;
                cmd.start_draw = accept && opcode == OP_DRAW;
            end
            ST_MUL_A: cmd.mul_a = 1'b1;
            ST_MUL_B: cmd.mul_b = 1'b1;
            ST_MIX_B:
            begin
                cmd.fin_mix = 1'b1;
                cnt_next    = '0;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> rtl/hashed_counter_random_range_top.sv
// Top level of the hashed counter random range block: joins controller and datapath.
// Uses hcrr_pkg, hcrr_ctrl, hcrr_datapath and the assertion macro header.
`default_nettype none

`include "hashed_counter_random_range_top_defines.svh"

// A load item copies seed_value into the counter at the edge that accepts it and gives
// no result. A draw item steps the counter at the edge that accepts it, and its result
// is worked out in order: ST_MUL_A, ST_MUL_B and ST_MIX_B for the two multiply-xorshift
// rounds (one 32-bit multiply in each of the first two), ST_DIV for the restoring
// remainder unit that retires one quotient bit a cycle, and ST_DONE to load the output
// register once it is free. With a zero range the ST_DIV steps are skipped. The input is
// closed while a draw is worked on. The next item is accepted in the first cycle in which
// the result sits in the output register, even if it has not been taken yet. A result
// that is not taken holds the following draw in ST_DONE.
module hashed_counter_random_range_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire hcrr_pkg::opcode_t                   opcode,
    input  wire logic        [hcrr_pkg::WORD_W-1:0]  seed_value,
    input  wire logic signed [hcrr_pkg::WORD_W-1:0]  min_value,
    input  wire logic signed [hcrr_pkg::WORD_W-1:0]  max_value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic             [hcrr_pkg::WORD_W-1:0]  raw_word,
    output logic signed      [hcrr_pkg::WORD_W-1:0]  ranged_value,
    output logic                                     range_error
);
    import hcrr_pkg::*;

    cmd_t              cmd;
    status_t           status;
    logic [WORD_W-1:0] ranged_u;

    hcrr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    hcrr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .seed_value   (seed_value),
        .min_value    ($unsigned(min_value)),
        .max_value    ($unsigned(max_value)),
        .raw_word     (raw_word),
        .ranged_value (ranged_u),
        .range_error  (range_error)
    );

    assign ranged_value = $signed(ranged_u);

    // A draw keeps the input side closed while it is worked on.
    `HCRR_ASSERT_NEXT(a_draw_busy, clk, rst_n, in_valid && in_ready && opcode == OP_DRAW, !in_ready)
    // A load finishes in the cycle it is accepted.
    `HCRR_ASSERT_NEXT(a_load_quick, clk, rst_n, in_valid && in_ready && opcode == OP_LOAD, in_ready)
    // A new result only appears at the end of a draw's work.
    `HCRR_ASSERT_IMPL(a_out_after_work, clk, rst_n, $rose(out_valid), !$past(in_ready))

endmodule

`default_nettype wire
